@@ rtl/kvbt_pkg.sv @@
// Shared constants, codes and types of the KV block table address translator.
package kvbt_pkg;

    // Sizing
    localparam int MAX_BATCHES          = 16;
    localparam int MAX_BLOCKS_PER_BATCH = 256;
    localparam int TOKENS_PER_BLOCK     = 128;

    localparam int BATCH_IDX_W  = $clog2(MAX_BATCHES);
    localparam int COL_IDX_W    = $clog2(MAX_BLOCKS_PER_BATCH);
    localparam int TABLE_DEPTH  = MAX_BATCHES * MAX_BLOCKS_PER_BATCH;
    localparam int TABLE_ADDR_W = $clog2(TABLE_DEPTH);
    localparam int TOKEN_LO_W   = $clog2(TOKENS_PER_BLOCK);

    // Field widths
    localparam int MODE_W       = 2;
    localparam int BATCH_W      = 4;
    localparam int COLUMN_W     = 8;
    localparam int ENTRY_W      = 32;
    localparam int COUNT_W      = 16;
    localparam int POS_W        = 32;
    localparam int STATUS_W     = 3;
    localparam int OFFSET_W     = 54;
    localparam int ROW_BYTES_W  = 16;
    localparam int COL_LIMIT_W  = 9;

    // Derived datapath widths
    localparam int POS_COL_W    = POS_W - 1 - TOKEN_LO_W;   // column of a non-negative position
    localparam int ROW_W        = ENTRY_W - 1 + TOKEN_LO_W; // block * tokens per block + position
    localparam int PROD_W       = ROW_W + ROW_BYTES_W;
    localparam int LIMIT_CMP_W  = (POS_COL_W > COL_LIMIT_W) ? POS_COL_W : COL_LIMIT_W;
    localparam int COUNT_MAX    = (1 << COUNT_W) - 1;

    // Configuration port
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;
    localparam int REG_IDX_W    = 2;

    localparam logic [REG_IDX_W-1:0] REG_ROW_BYTES   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SRC_BLOCKS  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DST_BLOCKS  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_COPY_CAP    = 2'd3;

    localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST  = 16'd656;
    localparam logic [COL_LIMIT_W-1:0] SRC_BLOCKS_RST = 9'd256;
    localparam logic [COL_LIMIT_W-1:0] DST_BLOCKS_RST = 9'd256;
    localparam logic [COUNT_W-1:0]     COPY_CAP_RST   = 16'd1024;

    typedef enum logic [MODE_W-1:0] {
        MODE_RESOLVE   = 2'd0,
        MODE_WR_SRC    = 2'd1,
        MODE_WR_DST    = 2'd2,
        MODE_WR_COUNT  = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_VALID        = 3'd0,
        ST_BEYOND_COUNT = 3'd1,
        ST_NEG_ID       = 3'd2,
        ST_COL_RANGE    = 3'd3,
        ST_UNMAPPED     = 3'd4
    } status_t;

    // Table RAM write/read control
    typedef struct packed {
        logic                    we;
        logic [TABLE_ADDR_W-1:0] waddr;
        logic [ENTRY_W-1:0]      wdata;
        logic                    re;
        logic [TABLE_ADDR_W-1:0] raddr;
    } ram_ctrl_t;

endpackage

@@ rtl/kvbt_if.sv @@
// Request and result channel interfaces of the KV block table translator.
interface kvbt_item_if;
    import kvbt_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [MODE_W-1:0]          mode;
    logic [BATCH_W-1:0]         batch;
    logic [COLUMN_W-1:0]        column;
    logic signed [ENTRY_W-1:0]  table_entry;
    logic [COUNT_W-1:0]         copy_index;
    logic signed [POS_W-1:0]    source_token;
    logic signed [POS_W-1:0]    destination_slot;

    modport source (
        output valid, mode, batch, column, table_entry, copy_index,
               source_token, destination_slot,
        input  ready
    );

    modport sink (
        input  valid, mode, batch, column, table_entry, copy_index,
               source_token, destination_slot,
        output ready
    );
endinterface

interface kvbt_result_if;
    import kvbt_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [OFFSET_W-1:0]    source_byte_offset;
    logic [OFFSET_W-1:0]    destination_byte_offset;

    modport source (
        output valid, status, source_byte_offset, destination_byte_offset,
        input  ready
    );

    modport sink (
        input  valid, status, source_byte_offset, destination_byte_offset,
        output ready
    );
endinterface

@@ rtl/kvbt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module kvbt_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/kvbt_offset_mul.sv @@
// Registered row-to-byte-offset multiplier.
module kvbt_offset_mul
    import kvbt_pkg::*;
(
    input  logic                   clk,
    input  logic                   en,
    input  logic [ROW_W-1:0]       row,
    input  logic [ROW_BYTES_W-1:0] row_bytes,
    output logic [OFFSET_W-1:0]    offset
);
    logic [PROD_W-1:0]   prod;
    logic [OFFSET_W-1:0] offset_reg;

    assign prod = PROD_W'(row) * PROD_W'(row_bytes);

    // offset wraps modulo 2^OFFSET_W
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            offset_reg <= OFFSET_W'(prod);
        end
    end

    assign offset = offset_reg;
endmodule

@@ rtl/kv_block_table_scatter_addr.sv @@
// Top level of the paged KV cache block table address translator.
//
// Usage:
//   item   : request channel (valid/ready). mode selects a resolve or a
//            write of the source table, destination table or batch count.
//            Writes take effect at the accepting edge and produce no result.
//   result : one result per resolve request: status and two 54-bit byte
//            offsets (zero unless status is valid).
//   APB    : four registers at byte addresses 0x0, 0x4, 0x8, 0xC
//            (row_bytes, source_blocks_per_batch, dest_blocks_per_batch,
//            copy_cap); pready is tied high, reads return the register.
//   Throughput: one request per cycle unless stalled. A resolve does its
//   checks at accept, reads both block tables (synchronous RAM), then runs
//   one 38x16 multiplier per side; it passes the stage 1, stage 2 and
//   output stage registers before result.valid rises.
//   Writes and reads of the tables both happen at the accept edge, so
//   back-to-back write/resolve pairs see each other in order.
//   Stall: when a result waits and result.ready is low the whole pipe
//   freezes and item.ready drops; nothing is lost.
//   Reset: counts clear to zero, registers load their defaults, pipe empty.
//   The table RAMs are not cleared; they hold garbage until written.
module kv_block_table_scatter_addr
    import kvbt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    kvbt_item_if.sink             item,
    kvbt_result_if.source         result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);
    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [ROW_BYTES_W-1:0] row_bytes_reg;
    logic [COL_LIMIT_W-1:0] src_blocks_reg;
    logic [COL_LIMIT_W-1:0] dst_blocks_reg;
    logic [COUNT_W-1:0]     copy_cap_reg;
    logic                   cfg_wr;
    logic [REG_IDX_W-1:0]   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[REG_IDX_W+1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg  <= ROW_BYTES_RST;
            src_blocks_reg <= SRC_BLOCKS_RST;
            dst_blocks_reg <= DST_BLOCKS_RST;
            copy_cap_reg   <= COPY_CAP_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_ROW_BYTES:  row_bytes_reg  <= pwdata[ROW_BYTES_W-1:0];
                REG_SRC_BLOCKS: src_blocks_reg <= pwdata[COL_LIMIT_W-1:0];
                REG_DST_BLOCKS: dst_blocks_reg <= pwdata[COL_LIMIT_W-1:0];
                REG_COPY_CAP:   copy_cap_reg   <= pwdata[COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_ROW_BYTES:  prdata = APB_DATA_W'(row_bytes_reg);
            REG_SRC_BLOCKS: prdata = APB_DATA_W'(src_blocks_reg);
            REG_DST_BLOCKS: prdata = APB_DATA_W'(dst_blocks_reg);
            REG_COPY_CAP:   prdata = APB_DATA_W'(copy_cap_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Pipe control: everything advances unless a result is stuck
    // ---------------------------------------------------------------
    logic en;
    logic accept;
    logic out_valid_reg;
    mode_t mode;

    assign en         = !out_valid_reg || result.ready;
    assign item.ready = en;
    assign accept     = item.valid && item.ready;
    assign mode       = mode_t'(item.mode);

    // ---------------------------------------------------------------
    // Request decode at accept
    // ---------------------------------------------------------------
    logic                   batch_ok;
    logic                   col_ok;
    logic [BATCH_IDX_W-1:0] batch_idx;
    logic [COL_IDX_W-1:0]   col_idx;
    logic [POS_COL_W-1:0]   src_col;
    logic [POS_COL_W-1:0]   dst_col;
    logic [COL_LIMIT_W-1:0] src_lim;
    logic [COL_LIMIT_W-1:0] dst_lim;
    logic [COUNT_W-1:0]     count_raw;
    logic [COUNT_W-1:0]     count_eff;
    logic [COUNT_W-1:0]     count_wdata;
    logic                   neg_id;
    logic                   col_bad;
    status_t                pre_status;
    ram_ctrl_t              src_ram;
    ram_ctrl_t              dst_ram;
    logic [COUNT_W-1:0]     count_reg [MAX_BATCHES];

    assign batch_ok  = 32'(item.batch) < MAX_BATCHES;
    assign col_ok    = 32'(item.column) < MAX_BLOCKS_PER_BATCH;
    assign batch_idx = item.batch[BATCH_IDX_W-1:0];
    assign col_idx   = item.column[COL_IDX_W-1:0];

    // block column of each position; only meaningful for non-negative ones
    assign src_col = item.source_token[POS_W-2:TOKEN_LO_W];
    assign dst_col = item.destination_slot[POS_W-2:TOKEN_LO_W];

    // effective column limit: smaller of register and table width
    assign src_lim = (32'(src_blocks_reg) > MAX_BLOCKS_PER_BATCH)
                   ? COL_LIMIT_W'(MAX_BLOCKS_PER_BATCH) : src_blocks_reg;
    assign dst_lim = (32'(dst_blocks_reg) > MAX_BLOCKS_PER_BATCH)
                   ? COL_LIMIT_W'(MAX_BLOCKS_PER_BATCH) : dst_blocks_reg;

    assign count_raw = batch_ok ? count_reg[batch_idx] : '0;
    assign count_eff = (count_raw > copy_cap_reg) ? copy_cap_reg : count_raw;
    assign neg_id    = item.source_token[POS_W-1] || item.destination_slot[POS_W-1];
    assign col_bad   = (LIMIT_CMP_W'(src_col) >= LIMIT_CMP_W'(src_lim))
                    || (LIMIT_CMP_W'(dst_col) >= LIMIT_CMP_W'(dst_lim));

    always_comb
    begin
        priority if (item.copy_index >= count_eff)
            pre_status = ST_BEYOND_COUNT;
        else if (neg_id)
            pre_status = ST_NEG_ID;
        else if (col_bad)
            pre_status = ST_COL_RANGE;
        else
            pre_status = ST_VALID;
    end

    // count write: negative stores zero, large values saturate
    always_comb
    begin
        priority if (item.table_entry[ENTRY_W-1])
            count_wdata = '0;
        else if (item.table_entry > ENTRY_W'(COUNT_MAX))
            count_wdata = COUNT_W'(COUNT_MAX);
        else
            count_wdata = item.table_entry[COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_BATCHES; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else if (accept && mode == MODE_WR_COUNT && batch_ok)
        begin
            count_reg[batch_idx] <= count_wdata;
        end
    end

    // table RAM ports: write on a table write, read on every resolve
    always_comb
    begin
        src_ram.we    = accept && mode == MODE_WR_SRC && batch_ok && col_ok;
        src_ram.waddr = {batch_idx, col_idx};
        src_ram.wdata = item.table_entry;
        src_ram.re    = accept && mode == MODE_RESOLVE;
        src_ram.raddr = {batch_idx, src_col[COL_IDX_W-1:0]};

        dst_ram.we    = accept && mode == MODE_WR_DST && batch_ok && col_ok;
        dst_ram.waddr = {batch_idx, col_idx};
        dst_ram.wdata = item.table_entry;
        dst_ram.re    = src_ram.re;
        dst_ram.raddr = {batch_idx, dst_col[COL_IDX_W-1:0]};
    end

    logic [ENTRY_W-1:0] src_blk;
    logic [ENTRY_W-1:0] dst_blk;

    kvbt_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(ENTRY_W)) u_src_table (
        .clk   (clk),
        .we    (src_ram.we),
        .waddr (src_ram.waddr),
        .wdata (src_ram.wdata),
        .re    (src_ram.re),
        .raddr (src_ram.raddr),
        .rdata (src_blk)
    );

    kvbt_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(ENTRY_W)) u_dst_table (
        .clk   (clk),
        .we    (dst_ram.we),
        .waddr (dst_ram.waddr),
        .wdata (dst_ram.wdata),
        .re    (dst_ram.re),
        .raddr (dst_ram.raddr),
        .rdata (dst_blk)
    );

    // ---------------------------------------------------------------
    // Stage 1: table data arrives, unmapped check, row forming
    // ---------------------------------------------------------------
    logic                  s1_valid_reg;
    status_t               s1_status_reg;
    logic [TOKEN_LO_W-1:0] s1_src_lo_reg;
    logic [TOKEN_LO_W-1:0] s1_dst_lo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= accept && mode == MODE_RESOLVE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_status_reg <= pre_status;
            s1_src_lo_reg <= item.source_token[TOKEN_LO_W-1:0];
            s1_dst_lo_reg <= item.destination_slot[TOKEN_LO_W-1:0];
        end
    end

    status_t          s1_status;
    logic [ROW_W-1:0] s1_src_row;
    logic [ROW_W-1:0] s1_dst_row;

    always_comb
    begin
        s1_status = s1_status_reg;
        if (s1_status_reg == ST_VALID && (src_blk[ENTRY_W-1] || dst_blk[ENTRY_W-1]))
        begin
            s1_status = ST_UNMAPPED;
        end
        // non-valid pairs carry zero rows so the offsets come out zero
        if (s1_status == ST_VALID)
        begin
            s1_src_row = {src_blk[ENTRY_W-2:0], s1_src_lo_reg};
            s1_dst_row = {dst_blk[ENTRY_W-2:0], s1_dst_lo_reg};
        end
        else
        begin
            s1_src_row = '0;
            s1_dst_row = '0;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: rows registered ahead of the multipliers
    // ---------------------------------------------------------------
    logic             s2_valid_reg;
    status_t          s2_status_reg;
    logic [ROW_W-1:0] s2_src_row_reg;
    logic [ROW_W-1:0] s2_dst_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_status_reg  <= s1_status;
            s2_src_row_reg <= s1_src_row;
            s2_dst_row_reg <= s1_dst_row;
        end
    end

    // ---------------------------------------------------------------
    // Output stage: offsets from one multiplier per side
    // ---------------------------------------------------------------
    status_t out_status_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_status_reg <= s2_status_reg;
        end
    end

    kvbt_offset_mul u_src_mul (
        .clk       (clk),
        .en        (en),
        .row       (s2_src_row_reg),
        .row_bytes (row_bytes_reg),
        .offset    (result.source_byte_offset)
    );

    kvbt_offset_mul u_dst_mul (
        .clk       (clk),
        .en        (en),
        .row       (s2_dst_row_reg),
        .row_bytes (row_bytes_reg),
        .offset    (result.destination_byte_offset)
    );

    assign result.valid  = out_valid_reg;
    assign result.status = out_status_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_resolve_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode == MODE_RESOLVE) |=> s1_valid_reg)
        else $error("resolve request did not enter stage 1");

    a_result_from_stage2: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(s2_valid_reg))
        else $error("result appeared without a resolve in stage 2");

    a_zero_unless_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status != ST_VALID) |->
            (result.source_byte_offset == '0 && result.destination_byte_offset == '0))
        else $error("nonzero offset on a skipped pair");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.status <= ST_UNMAPPED))
        else $error("status code out of range");
endmodule
